### rtl/core/sbwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbwf_pkg;

    // Bus protocol constants
    localparam logic [7:0] SYNC_BYTE      = 8'hFF;
    localparam logic [7:0] YAW_SERVO_ID   = 8'd1;
    localparam logic [7:0] PITCH_SERVO_ID = 8'd2;
    localparam logic [7:0] WRITE_OPCODE   = 8'h03;
    localparam logic [7:0] ADDR_TORQUE    = 8'd40;
    localparam logic [7:0] ADDR_GOAL      = 8'd42;
    // Length byte is the data length plus three.
    localparam logic [7:0] LEN_GOAL    = 8'd9;
    localparam logic [7:0] LEN_TORQUE  = 8'd4;

    // Field widths
    localparam int POS_W   = 10;
    localparam int ANGLE_W = 13;
    localparam int SPEED_W = 16;
    localparam int STEP_W  = 5;

    // Steps of one packet in the program, and the base of the pitch packet.
    localparam logic [STEP_W-1:0] PKT_STEPS   = 5'd14;
    localparam logic [STEP_W-1:0] PROG_STEPS  = 5'd28;

    // Reciprocal of five in 18 fractional bits; exact floor for values below 2^18.
    localparam logic [15:0] RECIP5     = 16'd52429;
    localparam int          RECIP5_SHR = 18;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_YAW_ZERO   = 3'd0,
        CFG_PITCH_ZERO = 3'd1,
        CFG_YAW_MIN    = 3'd2,
        CFG_YAW_MAX    = 3'd3,
        CFG_PITCH_MIN  = 3'd4,
        CFG_PITCH_MAX  = 3'd5,
        CFG_MOVE_SPEED = 3'd6
    } cfg_index_t;

    // Configuration reset values
    localparam logic [POS_W-1:0]   RST_YAW_ZERO   = 10'd460;
    localparam logic [POS_W-1:0]   RST_PITCH_ZERO = 10'd620;
    localparam logic [POS_W-1:0]   RST_YAW_MIN    = 10'd50;
    localparam logic [POS_W-1:0]   RST_YAW_MAX    = 10'd870;
    localparam logic [POS_W-1:0]   RST_PITCH_MIN  = 10'd620;
    localparam logic [POS_W-1:0]   RST_PITCH_MAX  = 10'd908;
    localparam logic [SPEED_W-1:0] RST_MOVE_SPEED = 16'd400;

    // Byte source selected by a control word
    typedef enum logic [3:0] {
        SRC_SYNC,
        SRC_ID,
        SRC_LEN,
        SRC_INST,
        SRC_ADDR,
        SRC_POS_HI,
        SRC_POS_LO,
        SRC_ZERO,
        SRC_SPD_HI,
        SRC_SPD_LO,
        SRC_TORQUE,
        SRC_CSUM
    } byte_src_t;

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_LOAD,
        SUM_ADD
    } sum_op_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_TORQUE,
        JMP_ALWAYS
    } jump_t;

    typedef enum logic {
        AXIS_YAW,
        AXIS_PITCH
    } axis_t;

    // One microcode control word
    typedef struct packed {
        byte_src_t         src;
        axis_t             axis;
        sum_op_t           sum_op;
        jump_t             jump;
        logic [STEP_W-1:0] target;
        logic              pkt_end;
        logic              cmd_end;
    } ucode_word_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

endpackage

`default_nettype wire

### rtl/core/servo_bus_write_packet_framer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Servo bus write packet framer. Each accepted command becomes the byte stream
// of two write packets, yaw servo (id 1) then pitch servo (id 2): 26 bytes in
// move mode, 16 in torque mode, one byte per cycle while the sink keeps
// m_tready high, with m_tuser marking each checksum byte and m_tlast the final
// byte of the command. A microcode step counter walks a 28-word program, one
// word per output byte; s_tready returns high as the final byte enters the
// output register. The angle to position conversion runs in a three-stage
// pipeline behind the packet header. The configuration port may only be
// written while no command is in progress.
module servo_bus_write_packet_framer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Command input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // yaw_angle[12:0], pitch_angle[25:13],
                                        // torque_on[26], zero fill[31:27]
    input  wire logic        s_tuser,   // mode[0]
    // Bus byte output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // tx_byte[7:0]
    output logic             m_tuser,   // packet_end[0]
    output logic             m_tlast,
    // Configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    logic [sbwf_pkg::POS_W-1:0]   yaw_zero_reg, pitch_zero_reg;
    logic [sbwf_pkg::POS_W-1:0]   yaw_min_reg, yaw_max_reg, pitch_min_reg, pitch_max_reg;
    logic [sbwf_pkg::SPEED_W-1:0] move_speed_reg;

    sbwf_pkg::seq_state_t        state_reg, state_next;
    logic [sbwf_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        mode_reg, torque_reg;
    logic                        m_tvalid_reg;
    logic [7:0]                  m_tdata_reg;
    logic                        m_tuser_reg, m_tlast_reg;

    logic                        in_xfer;
    logic                        out_free;
    logic                        advance;
    logic                        jump_taken;
    sbwf_pkg::ucode_word_t       word;
    logic [7:0]                  tx_byte;
    logic [sbwf_pkg::POS_W-1:0]  yaw_pos, pitch_pos;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_zero_reg   <= sbwf_pkg::RST_YAW_ZERO;
            pitch_zero_reg <= sbwf_pkg::RST_PITCH_ZERO;
            yaw_min_reg    <= sbwf_pkg::RST_YAW_MIN;
            yaw_max_reg    <= sbwf_pkg::RST_YAW_MAX;
            pitch_min_reg  <= sbwf_pkg::RST_PITCH_MIN;
            pitch_max_reg  <= sbwf_pkg::RST_PITCH_MAX;
            move_speed_reg <= sbwf_pkg::RST_MOVE_SPEED;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sbwf_pkg::CFG_YAW_ZERO:   yaw_zero_reg   <= cfg_wdata[sbwf_pkg::POS_W-1:0];
                sbwf_pkg::CFG_PITCH_ZERO: pitch_zero_reg <= cfg_wdata[sbwf_pkg::POS_W-1:0];
                sbwf_pkg::CFG_YAW_MIN:    yaw_min_reg    <= cfg_wdata[sbwf_pkg::POS_W-1:0];
                sbwf_pkg::CFG_YAW_MAX:    yaw_max_reg    <= cfg_wdata[sbwf_pkg::POS_W-1:0];
                sbwf_pkg::CFG_PITCH_MIN:  pitch_min_reg  <= cfg_wdata[sbwf_pkg::POS_W-1:0];
                sbwf_pkg::CFG_PITCH_MAX:  pitch_max_reg  <= cfg_wdata[sbwf_pkg::POS_W-1:0];
                sbwf_pkg::CFG_MOVE_SPEED: move_speed_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer outputs
    always_comb begin
        s_tready   = (state_reg == sbwf_pkg::SEQ_IDLE);
        in_xfer    = s_tvalid && s_tready;
        out_free   = !m_tvalid_reg || m_tready;
        advance    = (state_reg == sbwf_pkg::SEQ_RUN) && out_free;
        jump_taken = (word.jump == sbwf_pkg::JMP_ALWAYS) ||
                     ((word.jump == sbwf_pkg::JMP_TORQUE) && mode_reg);
    end

    // Sequencer next state and step
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            sbwf_pkg::SEQ_IDLE: begin
                if (in_xfer) begin
                    state_next = sbwf_pkg::SEQ_RUN;
                    step_next  = '0;
                end
            end
            sbwf_pkg::SEQ_RUN: begin
                if (advance) begin
                    priority if (word.cmd_end) begin
                        state_next = sbwf_pkg::SEQ_IDLE;
                        step_next  = '0;
                    end else if (jump_taken) begin
                        step_next = word.target;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: state_next = sbwf_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sbwf_pkg::SEQ_IDLE;
            step_reg   <= '0;
            mode_reg   <= 1'b0;
            torque_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (in_xfer) begin
                mode_reg <= s_tuser;
                // Torque value is only latched by a torque command.
                if (s_tuser) begin
                    torque_reg <= s_tdata[26];
                end
            end
        end
    end

    // Output register: loaded with one byte per step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= tx_byte;
            m_tuser_reg <= word.pkt_end;
            m_tlast_reg <= word.cmd_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    sbwf_ucode_rom u_rom (
        .step (step_reg),
        .word (word)
    );

    // Positions only update on move commands; torque commands leave them alone.
    sbwf_pos_unit u_yaw_pos (
        .aclk  (aclk),
        .start (in_xfer && !s_tuser),
        .zero  (yaw_zero_reg),
        .angle ($signed(s_tdata[12:0])),
        .lo    (yaw_min_reg),
        .hi    (yaw_max_reg),
        .pos   (yaw_pos)
    );

    sbwf_pos_unit u_pitch_pos (
        .aclk  (aclk),
        .start (in_xfer && !s_tuser),
        .zero  (pitch_zero_reg),
        .angle ($signed(s_tdata[25:13])),
        .lo    (pitch_min_reg),
        .hi    (pitch_max_reg),
        .pos   (pitch_pos)
    );

    sbwf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .word      (word),
        .advance   (advance),
        .mode      (mode_reg),
        .torque    (torque_reg),
        .yaw_pos   (yaw_pos),
        .pitch_pos (pitch_pos),
        .speed     (move_speed_reg),
        .tx_byte   (tx_byte)
    );

endmodule

`default_nettype wire

### rtl/core/sbwf_pos_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Angle to servo position: trunc((5*zero + angle) / 5), clamped to [lo, hi].
// Three register stages: offset and magnitude, reciprocal multiply, sign and clamp.
module sbwf_pos_unit (
    input  wire logic                               aclk,
    input  wire logic                               start,
    input  wire logic [sbwf_pkg::POS_W-1:0]         zero,
    input  wire logic signed [sbwf_pkg::ANGLE_W-1:0] angle,
    input  wire logic [sbwf_pkg::POS_W-1:0]         lo,
    input  wire logic [sbwf_pkg::POS_W-1:0]         hi,
    output logic      [sbwf_pkg::POS_W-1:0]         pos
);

    logic [12:0]        zero5;
    logic signed [14:0] sum_val;
    logic [13:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [29:0]        prod_next;
    logic [11:0]        quot_reg, quot_next;
    logic               neg2_reg;
    logic signed [12:0] p_val;
    logic signed [12:0] lo_s, hi_s;
    logic [sbwf_pkg::POS_W-1:0] pos_reg, pos_next;

    // Stage one: the signed offset and its magnitude.
    always_comb begin
        zero5    = {1'b0, zero, 2'b00} + {3'b000, zero};
        sum_val  = $signed({2'b00, zero5}) + $signed({{2{angle[12]}}, angle});
        neg_next = sum_val[14];
        mag_next = neg_next ? 14'(-sum_val) : sum_val[13:0];
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    // Stage two: divide the magnitude by five through the reciprocal.
    always_comb begin
        prod_next = {16'b0, mag_reg} * {14'b0, sbwf_pkg::RECIP5};
        quot_next = prod_next[sbwf_pkg::RECIP5_SHR +: 12];
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        neg2_reg <= neg_reg;
    end

    // Stage three: restore the sign, then clamp with the low bound tested first.
    always_comb begin
        p_val = neg2_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
        lo_s  = $signed({3'b000, lo});
        hi_s  = $signed({3'b000, hi});
        priority if (p_val < lo_s) begin
            pos_next = lo;
        end else if (p_val > hi_s) begin
            pos_next = hi;
        end else begin
            pos_next = p_val[sbwf_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

### rtl/core/sbwf_ucode_rom.sv
`timescale 1ns / 1ps
`default_nettype none

// Read-only program. Both packets share one 14-step body; the upper half of
// the program is the pitch packet.
module sbwf_ucode_rom (
    input  wire logic [sbwf_pkg::STEP_W-1:0] step,
    output sbwf_pkg::ucode_word_t            word
);

    function automatic sbwf_pkg::ucode_word_t mk(
        input sbwf_pkg::byte_src_t         src,
        input sbwf_pkg::axis_t             axis,
        input sbwf_pkg::sum_op_t           op,
        input sbwf_pkg::jump_t             jmp,
        input logic [sbwf_pkg::STEP_W-1:0] target,
        input logic                        pend,
        input logic                        cend
    );
        sbwf_pkg::ucode_word_t w;
        w.src     = src;
        w.axis    = axis;
        w.sum_op  = op;
        w.jump    = jmp;
        w.target  = target;
        w.pkt_end = pend;
        w.cmd_end = cend;
        return w;
    endfunction

    sbwf_pkg::axis_t             axis;
    logic [sbwf_pkg::STEP_W-1:0] base;
    logic [sbwf_pkg::STEP_W-1:0] off;
    logic                        is_pitch;

    always_comb begin
        is_pitch = (step >= sbwf_pkg::PKT_STEPS);
        axis     = is_pitch ? sbwf_pkg::AXIS_PITCH : sbwf_pkg::AXIS_YAW;
        base     = is_pitch ? sbwf_pkg::PKT_STEPS : '0;
        off      = step - base;
    end

    always_comb begin
        if (step >= sbwf_pkg::PROG_STEPS) begin
            // Unused steps end the command safely.
            word = mk(sbwf_pkg::SRC_CSUM, axis, sbwf_pkg::SUM_HOLD, sbwf_pkg::JMP_NONE,
                      '0, 1'b1, 1'b1);
        end else begin
            unique case (off)
                5'd0, 5'd1: word = mk(sbwf_pkg::SRC_SYNC, axis, sbwf_pkg::SUM_HOLD,
                                      sbwf_pkg::JMP_NONE, '0, 1'b0, 1'b0);
                5'd2:  word = mk(sbwf_pkg::SRC_ID, axis, sbwf_pkg::SUM_LOAD,
                                 sbwf_pkg::JMP_NONE, '0, 1'b0, 1'b0);
                5'd3:  word = mk(sbwf_pkg::SRC_LEN, axis, sbwf_pkg::SUM_ADD,
                                 sbwf_pkg::JMP_NONE, '0, 1'b0, 1'b0);
                5'd4:  word = mk(sbwf_pkg::SRC_INST, axis, sbwf_pkg::SUM_ADD,
                                 sbwf_pkg::JMP_NONE, '0, 1'b0, 1'b0);
                5'd5:  word = mk(sbwf_pkg::SRC_ADDR, axis, sbwf_pkg::SUM_ADD,
                                 sbwf_pkg::JMP_TORQUE, base + 5'd12, 1'b0, 1'b0);
                5'd6:  word = mk(sbwf_pkg::SRC_POS_HI, axis, sbwf_pkg::SUM_ADD,
                                 sbwf_pkg::JMP_NONE, '0, 1'b0, 1'b0);
                5'd7:  word = mk(sbwf_pkg::SRC_POS_LO, axis, sbwf_pkg::SUM_ADD,
                                 sbwf_pkg::JMP_NONE, '0, 1'b0, 1'b0);
                5'd8, 5'd9: word = mk(sbwf_pkg::SRC_ZERO, axis, sbwf_pkg::SUM_ADD,
                                      sbwf_pkg::JMP_NONE, '0, 1'b0, 1'b0);
                5'd10: word = mk(sbwf_pkg::SRC_SPD_HI, axis, sbwf_pkg::SUM_ADD,
                                 sbwf_pkg::JMP_NONE, '0, 1'b0, 1'b0);
                5'd11: word = mk(sbwf_pkg::SRC_SPD_LO, axis, sbwf_pkg::SUM_ADD,
                                 sbwf_pkg::JMP_ALWAYS, base + 5'd13, 1'b0, 1'b0);
                5'd12: word = mk(sbwf_pkg::SRC_TORQUE, axis, sbwf_pkg::SUM_ADD,
                                 sbwf_pkg::JMP_NONE, '0, 1'b0, 1'b0);
                5'd13: word = mk(sbwf_pkg::SRC_CSUM, axis, sbwf_pkg::SUM_HOLD,
                                 sbwf_pkg::JMP_NONE, '0, 1'b1, is_pitch);
                default: word = mk(sbwf_pkg::SRC_CSUM, axis, sbwf_pkg::SUM_HOLD,
                                   sbwf_pkg::JMP_NONE, '0, 1'b1, 1'b1);
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/sbwf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte selection and the running checksum, driven by the current control word.
module sbwf_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire sbwf_pkg::ucode_word_t        word,
    input  wire logic                         advance,
    input  wire logic                         mode,
    input  wire logic                         torque,
    input  wire logic [sbwf_pkg::POS_W-1:0]   yaw_pos,
    input  wire logic [sbwf_pkg::POS_W-1:0]   pitch_pos,
    input  wire logic [sbwf_pkg::SPEED_W-1:0] speed,
    output logic      [7:0]                   tx_byte
);

    logic [7:0]                 sum_reg, sum_next;
    logic [sbwf_pkg::POS_W-1:0] pos;

    // Select the byte for this step.
    always_comb begin
        pos = (word.axis == sbwf_pkg::AXIS_PITCH) ? pitch_pos : yaw_pos;
        unique case (word.src)
            sbwf_pkg::SRC_SYNC:   tx_byte = sbwf_pkg::SYNC_BYTE;
            sbwf_pkg::SRC_ID:     tx_byte = (word.axis == sbwf_pkg::AXIS_PITCH) ?
                                            sbwf_pkg::PITCH_SERVO_ID :
                                            sbwf_pkg::YAW_SERVO_ID;
            sbwf_pkg::SRC_LEN:    tx_byte = mode ? sbwf_pkg::LEN_TORQUE : sbwf_pkg::LEN_GOAL;
            sbwf_pkg::SRC_INST:   tx_byte = sbwf_pkg::WRITE_OPCODE;
            sbwf_pkg::SRC_ADDR:   tx_byte = mode ? sbwf_pkg::ADDR_TORQUE : sbwf_pkg::ADDR_GOAL;
            sbwf_pkg::SRC_POS_HI: tx_byte = {6'b000000, pos[9:8]};
            sbwf_pkg::SRC_POS_LO: tx_byte = pos[7:0];
            sbwf_pkg::SRC_ZERO:   tx_byte = 8'h00;
            sbwf_pkg::SRC_SPD_HI: tx_byte = speed[15:8];
            sbwf_pkg::SRC_SPD_LO: tx_byte = speed[7:0];
            sbwf_pkg::SRC_TORQUE: tx_byte = {7'b0000000, torque};
            sbwf_pkg::SRC_CSUM:   tx_byte = ~sum_reg;
            default:              tx_byte = 8'h00;
        endcase
    end

    // Checksum accumulates id through the last data byte.
    always_comb begin
        unique case (word.sum_op)
            sbwf_pkg::SUM_LOAD: sum_next = tx_byte;
            sbwf_pkg::SUM_ADD:  sum_next = sum_reg + tx_byte;
            default:            sum_next = sum_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (advance) begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sbwf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the framer.
module sbwf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // A stalled output byte holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output byte changed while stalled");

    // A command transfer drops s_tready right after it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a command transfer");

    // The final byte of a command is always a checksum byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("last byte is not a checksum byte");

    // The input reopens only once the final byte is presented.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(s_tready)) |-> (m_tvalid && m_tlast))
        else $error("input reopened before the final byte");

endmodule

bind servo_bus_write_packet_framer_unit sbwf_checker u_sbwf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/tb_servo_bus_write_packet_framer_unit.sv
`timescale 1ns / 1ps

// Command modes carried on s_tuser.
localparam logic MODE_MOVE   = 1'b0;
localparam logic MODE_TORQUE = 1'b1;

// Register index past the end of the list; writes to it must change nothing.
localparam logic [2:0] CFG_UNUSED = 3'd7;

// One command: the mode travels on s_tuser, the other fields on s_tdata.
typedef struct packed {
    logic        torque_on;
    logic [12:0] pitch_angle;
    logic [12:0] yaw_angle;
    logic        mode;
} command_t;

// One byte on the servo bus together with its markers.
typedef struct packed {
    logic [7:0] tx_byte;
    logic       packet_end;
    logic       last;
} bus_byte_t;

// A full set of configuration registers.
typedef struct packed {
    logic [15:0] move_speed;
    logic [9:0]  pitch_max;
    logic [9:0]  pitch_min;
    logic [9:0]  yaw_max;
    logic [9:0]  yaw_min;
    logic [9:0]  pitch_zero;
    logic [9:0]  yaw_zero;
} settings_t;

// Predicts the bus bytes of each accepted command and checks the bytes that leave.
class packet_scoreboard;
    bus_byte_t   expected_bytes[$];
    logic [9:0]  yaw_zero, pitch_zero, yaw_min, yaw_max, pitch_min, pitch_max;
    logic [15:0] move_speed;
    int          mismatches;
    int          bytes_seen;

    function new();
        yaw_zero   = sbwf_pkg::RST_YAW_ZERO;
        pitch_zero = sbwf_pkg::RST_PITCH_ZERO;
        yaw_min    = sbwf_pkg::RST_YAW_MIN;
        yaw_max    = sbwf_pkg::RST_YAW_MAX;
        pitch_min  = sbwf_pkg::RST_PITCH_MIN;
        pitch_max  = sbwf_pkg::RST_PITCH_MAX;
        move_speed = sbwf_pkg::RST_MOVE_SPEED;
        mismatches = 0;
        bytes_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] value);
        case (idx)
            sbwf_pkg::CFG_YAW_ZERO:   yaw_zero   = value[9:0];
            sbwf_pkg::CFG_PITCH_ZERO: pitch_zero = value[9:0];
            sbwf_pkg::CFG_YAW_MIN:    yaw_min    = value[9:0];
            sbwf_pkg::CFG_YAW_MAX:    yaw_max    = value[9:0];
            sbwf_pkg::CFG_PITCH_MIN:  pitch_min  = value[9:0];
            sbwf_pkg::CFG_PITCH_MAX:  pitch_max  = value[9:0];
            sbwf_pkg::CFG_MOVE_SPEED: move_speed = value;
            default: ;
        endcase
    endfunction

    // Angle in 1/16 degree to servo steps (truncated toward zero), then clamped.
    // The lower bound is tested first, which decides the case of min above max.
    function logic [9:0] to_steps(logic [9:0] zero, logic [12:0] angle,
                                  logic [9:0] lo, logic [9:0] hi);
        int p;
        p = (int'(zero) * 5 + int'($signed(angle))) / 5;
        if (p < int'(lo)) return lo;
        if (p > int'(hi)) return hi;
        return p[9:0];
    endfunction

    function void push_byte(logic [7:0] b, logic pend);
        expected_bytes.push_back('{tx_byte: b, packet_end: pend, last: 1'b0});
    endfunction

    // Header, body and inverted checksum of one write packet.
    function void add_packet(logic [7:0] id, logic [7:0] addr, logic [7:0] body [6], int len);
        logic [7:0] sum;
        logic [7:0] len_byte;
        len_byte = 8'(len + 3);
        sum = id + len_byte + sbwf_pkg::WRITE_OPCODE + addr;
        push_byte(sbwf_pkg::SYNC_BYTE, 1'b0);
        push_byte(sbwf_pkg::SYNC_BYTE, 1'b0);
        push_byte(id, 1'b0);
        push_byte(len_byte, 1'b0);
        push_byte(sbwf_pkg::WRITE_OPCODE, 1'b0);
        push_byte(addr, 1'b0);
        for (int i = 0; i < len; i++) begin
            push_byte(body[i], 1'b0);
            sum = sum + body[i];
        end
        push_byte(~sum, 1'b1);
    endfunction

    // Goal position packet: position, time zero and speed, high byte first.
    function void add_goal_packet(logic [7:0] id, logic [9:0] pos);
        logic [7:0] body [6];
        body[0] = {6'b0, pos[9:8]};
        body[1] = pos[7:0];
        body[2] = 8'h00;
        body[3] = 8'h00;
        body[4] = move_speed[15:8];
        body[5] = move_speed[7:0];
        add_packet(id, sbwf_pkg::ADDR_GOAL, body, 6);
    endfunction

    function void note_command(command_t c);
        logic [7:0] body [6];
        if (c.mode == MODE_MOVE) begin
            add_goal_packet(sbwf_pkg::YAW_SERVO_ID,
                            to_steps(yaw_zero, c.yaw_angle, yaw_min, yaw_max));
            add_goal_packet(sbwf_pkg::PITCH_SERVO_ID,
                            to_steps(pitch_zero, c.pitch_angle, pitch_min, pitch_max));
        end else begin
            for (int i = 0; i < 6; i++) begin
                body[i] = 8'h00;
            end
            body[0] = {7'b0, c.torque_on};
            add_packet(sbwf_pkg::YAW_SERVO_ID, sbwf_pkg::ADDR_TORQUE, body, 1);
            add_packet(sbwf_pkg::PITCH_SERVO_ID, sbwf_pkg::ADDR_TORQUE, body, 1);
        end
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_byte(logic [7:0] b, logic pend, logic last);
        bus_byte_t want;
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
            report($sformatf("byte %0d: 0x%02h arrived with nothing expected", bytes_seen, b));
        end else begin
            want = expected_bytes.pop_front();
            if (b !== want.tx_byte) begin
                report($sformatf("byte %0d: tx_byte 0x%02h, expected 0x%02h",
                                 bytes_seen, b, want.tx_byte));
            end
            if (pend !== want.packet_end) begin
                report($sformatf("byte %0d: packet_end %b, expected %b",
                                 bytes_seen, pend, want.packet_end));
            end
            if (last !== want.last) begin
                report($sformatf("byte %0d: last %b, expected %b",
                                 bytes_seen, last, want.last));
            end
        end
    endtask
endclass

module tb_servo_bus_write_packet_framer_unit;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 30;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;

    logic             idle_on;
    int               quiet_cycles = 0;
    packet_scoreboard byte_checker;

    servo_bus_write_packet_framer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic command_t make_command(logic mode, int yaw, int pitch, logic torque);
        command_t c;
        c.mode        = mode;
        c.yaw_angle   = yaw[12:0];
        c.pitch_angle = pitch[12:0];
        c.torque_on   = torque;
        return c;
    endfunction

    // Mostly angles inside the mechanical range, some anywhere in 13 bits.
    function automatic logic [12:0] random_angle();
        int a;
        if ($urandom_range(0, 99) < 80) begin
            a = int'($urandom_range(0, 5760)) - 2880;
        end else begin
            a = $urandom_range(0, 8191);
        end
        return a[12:0];
    endfunction

    function automatic command_t random_command();
        command_t c;
        c.mode        = ($urandom_range(0, 99) < 25) ? MODE_TORQUE : MODE_MOVE;
        c.torque_on   = 1'($urandom_range(0, 1));
        c.yaw_angle   = random_angle();
        c.pitch_angle = random_angle();
        return c;
    endfunction

    // Fixed corner settings first, random ones after.
    function automatic settings_t phase_settings(int ph);
        settings_t s;
        case (ph)
            0: s = '{move_speed: 16'hFFFF, pitch_max: 10'd1000, pitch_min: 10'd0,
                     yaw_max: 10'd1000, yaw_min: 10'd0,
                     pitch_zero: 10'd1000, yaw_zero: 10'd1000};
            1: s = '{move_speed: 16'h0000, pitch_max: 10'd1000, pitch_min: 10'd0,
                     yaw_max: 10'd1000, yaw_min: 10'd0,
                     pitch_zero: 10'd0, yaw_zero: 10'd0};
            // Windows with the minimum above the maximum.
            2: s = '{move_speed: 16'h5AA5, pitch_max: 10'd0, pitch_min: 10'd1000,
                     yaw_max: 10'd300, yaw_min: 10'd700,
                     pitch_zero: 10'd500, yaw_zero: 10'd500};
            // Windows that are a single position.
            3: s = '{move_speed: 16'h8001, pitch_max: 10'd1000, pitch_min: 10'd1000,
                     yaw_max: 10'd0, yaw_min: 10'd0,
                     pitch_zero: 10'd1000, yaw_zero: 10'd0};
            default: begin
                s.yaw_zero   = 10'($urandom_range(0, 1000));
                s.pitch_zero = 10'($urandom_range(0, 1000));
                s.yaw_min    = 10'($urandom_range(0, 500));
                s.yaw_max    = 10'($urandom_range(300, 1000));
                s.pitch_min  = 10'($urandom_range(0, 500));
                s.pitch_max  = 10'($urandom_range(300, 1000));
                s.move_speed = 16'($urandom);
            end
        endcase
        return s;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        byte_checker.write_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Writes every register; with fill set, the unused upper bits of the
    // 10-bit registers carry random junk that must be dropped.
    task automatic apply_settings(input settings_t s, input logic fill);
        logic [5:0] junk;
        junk = fill ? 6'($urandom) : 6'b0;
        write_reg(sbwf_pkg::CFG_YAW_ZERO,   {junk, s.yaw_zero});
        write_reg(sbwf_pkg::CFG_PITCH_ZERO, {junk, s.pitch_zero});
        write_reg(sbwf_pkg::CFG_YAW_MIN,    {junk, s.yaw_min});
        write_reg(sbwf_pkg::CFG_YAW_MAX,    {junk, s.yaw_max});
        write_reg(sbwf_pkg::CFG_PITCH_MIN,  {junk, s.pitch_min});
        write_reg(sbwf_pkg::CFG_PITCH_MAX,  {junk, s.pitch_max});
        write_reg(sbwf_pkg::CFG_MOVE_SPEED, s.move_speed);
    endtask

    // Presents one command after a random gap and returns at the falling
    // edge after its transfer, with s_tvalid still high.
    task automatic send_command(input command_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {5'b0, c.torque_on, c.pitch_angle, c.yaw_angle};
        s_tuser  = c.mode;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        byte_checker.note_command(c);
        @(negedge aclk);
    endtask

    task automatic wait_drained(input int cycles);
        while (byte_checker.expected_bytes.size() != 0) @(negedge aclk);
        repeat (cycles) @(negedge aclk);
    endtask

    // Sink side: random stalls of m_tready.
    initial begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < 30) stall = pick_gap();
            end
        end
    end

    // Check every byte transfer on the output side.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            byte_checker.check_byte(m_tdata, m_tuser, m_tlast);
        end
    end

    // Stop the run if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = sbwf_pkg::CFG_YAW_ZERO;
        cfg_wdata = '0;
        idle_on   = 1'b1;
        byte_checker = new();
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed commands at the reset settings. Torque commands carry angles
        // and move commands carry a torque flag, both of which must be ignored.
        send_command(make_command(MODE_TORQUE, -1, -1, 1'b1));
        send_command(make_command(MODE_TORQUE, -2880, 2880, 1'b0));
        send_command(make_command(MODE_MOVE, 0, 0, 1'b0));
        send_command(make_command(MODE_MOVE, 2880, 2880, 1'b0));
        send_command(make_command(MODE_MOVE, -2880, -2880, 1'b1));
        send_command(make_command(MODE_MOVE, 4095, -4096, 1'b0));
        send_command(make_command(MODE_MOVE, -4096, 4095, 1'b1));
        send_command(make_command(MODE_MOVE, 1, -1, 1'b1));
        send_command(make_command(MODE_MOVE, -4, 4, 1'b0));
        send_command(make_command(MODE_MOVE, 1600, 1000, 1'b0));
        // Positions landing exactly on the window edges, and one step below the lower ones.
        send_command(make_command(MODE_MOVE, -2050, 5, 1'b0));
        send_command(make_command(MODE_MOVE, 2050, 1440, 1'b0));
        send_command(make_command(MODE_MOVE, 2054, 1444, 1'b0));
        send_command(make_command(MODE_MOVE, -2051, -1, 1'b0));
        send_command(make_command(MODE_TORQUE, 0, 0, 1'b1));
        send_command(make_command(MODE_TORQUE, 4095, -4096, 1'b0));

        // Random commands under a series of settings, changed only while idle.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            s_tvalid = 1'b0;
            wait_drained(SETTLE_CYCLES);
            apply_settings(phase_settings(ph), ph >= 4);
            if (ph == 2) write_reg(CFG_UNUSED, 16'hFFFF);
            idle_on = (ph % 3) != 1;
            repeat (ITEMS_PER_PHASE) send_command(random_command());
        end

        s_tvalid = 1'b0;
        wait_drained(END_CYCLES);
        if (byte_checker.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/sbwf_pkg.sv
rtl/core/sbwf_pos_unit.sv
rtl/core/sbwf_ucode_rom.sv
rtl/core/sbwf_datapath.sv
rtl/core/servo_bus_write_packet_framer_unit.sv
rtl/core/sbwf_checker.sv
tb/tb_servo_bus_write_packet_framer_unit.sv
